/* src/assert_macros.svh */
// assertion macros shared by the checker files
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/irtl_pkg.sv */
// shared types and constants for the ip range table lookup block
// no dependencies
package irtl_pkg;

    localparam int WORD_ADDR_BITS = 22;
    localparam int MAX_SCAN       = 256;
    localparam int SCAN_CNT_BITS  = $clog2(MAX_SCAN + 1);

    // first range-list word: byte 4 + 256*256*8
    localparam logic [WORD_ADDR_BITS-1:0] LIST_BASE_WORD =
        WORD_ADDR_BITS'((4 + 256 * 256 * 8) / 4);

    localparam logic [SCAN_CNT_BITS-1:0] MAX_SCAN_CNT = SCAN_CNT_BITS'(MAX_SCAN);

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_OFF,
        ST_CNT,
        ST_LIM,
        ST_RD,
        ST_CMP
    } state_t;

    typedef struct packed {
        logic                      we;
        logic                      re;
        logic [WORD_ADDR_BITS-1:0] addr;
        logic [31:0]               wdata;
    } ram_req_t;

endpackage

/* src/irtl_ram.sv */
// single-port table memory, registered read data
// no dependencies
module irtl_ram #(
    parameter int ADDR_BITS = 22,
    parameter int DATA_BITS = 32
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [DATA_BITS-1:0] wdata,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [0:(1 << ADDR_BITS) - 1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

/* src/irtl_seq.sv */
// lookup sequencer: table writes, header reads, range-list scan, result register
// depends on irtl_pkg
module irtl_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                kind,
    input  logic [irtl_pkg::WORD_ADDR_BITS-1:0] word_addr,
    input  logic [31:0]                         word_data,
    input  logic [31:0]                         ip_addr,
    output logic                                busy,
    output logic                                done,
    output logic [31:0]                         record_addr,
    output logic                                matched_in_block,
    output irtl_pkg::ram_req_t                  ram_req,
    input  logic [31:0]                         ram_rdata
);

    import irtl_pkg::*;

    state_t                    state_reg, state_next;
    logic [15:0]               hi16_reg, hi16_next;
    logic [7:0]                octet_reg, octet_next;
    logic [31:0]               base_reg, base_next;
    logic [WORD_ADDR_BITS-1:0] widx_reg, widx_next;
    logic [SCAN_CNT_BITS-1:0]  limit_reg, limit_next;
    logic [SCAN_CNT_BITS-1:0]  idx_reg, idx_next;
    logic [31:0]               record_reg, record_next;
    logic                      matched_reg, matched_next;
    logic                      done_reg, done_next;

    logic [WORD_ADDR_BITS-1:0] first_widx;
    logic                      scan_end;
    logic                      hit;

    // first-level entry word index: 1 + hi16*2
    assign first_widx = WORD_ADDR_BITS'({hi16_reg, 1'b1});
    assign scan_end   = (idx_reg == limit_reg);
    assign hit        = !scan_end && (octet_reg <= ram_rdata[7:0]);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && kind == KIND_LOOKUP)
                begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE: state_next = ST_OFF;
            ST_OFF:  state_next = ST_CNT;
            ST_CNT:  state_next = ST_LIM;
            ST_LIM:  state_next = ST_RD;
            ST_RD:   state_next = ST_CMP;
            ST_CMP:
            begin
                if (hit || scan_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ram_req       = '0;
        ram_req.wdata = word_data;
        busy          = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy         = 1'b0;
                ram_req.we   = start && kind == KIND_WRITE;
                ram_req.addr = word_addr;
            end
            ST_BASE:
            begin
                ram_req.re   = 1'b1;
                ram_req.addr = '0;
            end
            ST_OFF:
            begin
                ram_req.re   = 1'b1;
                ram_req.addr = first_widx;
            end
            ST_CNT:
            begin
                ram_req.re   = 1'b1;
                ram_req.addr = first_widx + WORD_ADDR_BITS'(1);
            end
            ST_RD:
            begin
                ram_req.re   = 1'b1;
                ram_req.addr = widx_reg;
            end
            default:
            begin
                ram_req.re = 1'b0;
            end
        endcase
    end

    // datapath next values; read data arrives the cycle after its address
    always_comb
    begin
        hi16_next    = hi16_reg;
        octet_next   = octet_reg;
        base_next    = base_reg;
        widx_next    = widx_reg;
        limit_next   = limit_reg;
        idx_next     = idx_reg;
        record_next  = record_reg;
        matched_next = matched_reg;
        done_next    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                hi16_next  = ip_addr[31:16];
                octet_next = ip_addr[15:8];
            end
            ST_OFF:
            begin
                base_next = ram_rdata;
            end
            ST_CNT:
            begin
                // offset is taken word aligned
                widx_next = LIST_BASE_WORD + ram_rdata[WORD_ADDR_BITS+1:2];
            end
            ST_LIM:
            begin
                limit_next = (ram_rdata > 32'(MAX_SCAN)) ? MAX_SCAN_CNT
                                                         : ram_rdata[SCAN_CNT_BITS-1:0];
                idx_next   = '0;
            end
            ST_CMP:
            begin
                if (hit || scan_end)
                begin
                    record_next  = base_reg + {8'd0, ram_rdata[31:8]};
                    matched_next = hit;
                    done_next    = 1'b1;
                end
                else
                begin
                    idx_next  = idx_reg + SCAN_CNT_BITS'(1);
                    widx_next = widx_reg + WORD_ADDR_BITS'(1);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi16_reg    <= hi16_next;
        octet_reg   <= octet_next;
        base_reg    <= base_next;
        widx_reg    <= widx_next;
        limit_reg   <= limit_next;
        idx_reg     <= idx_next;
        record_reg  <= record_next;
        matched_reg <= matched_next;
    end

    assign done             = done_reg;
    assign record_addr      = record_reg;
    assign matched_in_block = matched_reg;

endmodule

/* src/ip_range_table_lookup.sv */
// IPv4 range-table lookup: a 2^22-word table memory holds a base word, a first-level
// index of (offset, count) pairs and range lists; lookups scan a list for the first
// word whose low byte is at least the third octet. A transaction is accepted when
// start is high and busy is low. A write (kind 0) stores one word in that cycle and
// busy stays low. A lookup (kind 1) keeps busy high through its header states, then
// a read and a compare state per list word read (matching position + 1, or
// min(count, 256) + 1 when nothing matches); every step goes through the single read
// port of the table memory, one address and one registered read word at a time. done
// pulses for one cycle as busy falls, with record_addr and matched_in_block valid in
// that cycle only; the receiver cannot stall it. The memory has no reset and no
// clearing pass: every word a lookup touches must be written first.
// depends on irtl_pkg, irtl_seq, irtl_ram
module ip_range_table_lookup (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                kind,
    input  logic [irtl_pkg::WORD_ADDR_BITS-1:0] word_addr,
    input  logic [31:0]                         word_data,
    input  logic [31:0]                         ip_addr,
    output logic                                done,
    output logic [31:0]                         record_addr,
    output logic                                matched_in_block
);

    import irtl_pkg::*;

    ram_req_t    ram_req;
    logic [31:0] ram_rdata;

    irtl_seq u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .kind             (kind),
        .word_addr        (word_addr),
        .word_data        (word_data),
        .ip_addr          (ip_addr),
        .busy             (busy),
        .done             (done),
        .record_addr      (record_addr),
        .matched_in_block (matched_in_block),
        .ram_req          (ram_req),
        .ram_rdata        (ram_rdata)
    );

    irtl_ram #(
        .ADDR_BITS (WORD_ADDR_BITS),
        .DATA_BITS (32)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .re    (ram_req.re),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

endmodule

/* src/irtl_checker.sv */
// port-level checks for ip_range_table_lookup, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module irtl_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic kind,
    input logic done
);

    // a result only ends a lookup in progress
    `ASSERT_IMPL(a_done_after_busy, done, $past(busy) && !busy)
    // result strobe lasts one cycle
    `ASSERT_NEXT(a_done_pulse, done, !done)
    // a lookup transaction makes the block busy
    `ASSERT_NEXT(a_lookup_busy, start && !busy && kind, busy && !done)
    // a write transaction finishes in its own cycle with no result
    `ASSERT_NEXT(a_write_quiet, start && !busy && !kind, !busy && !done)

endmodule

bind ip_range_table_lookup irtl_checker u_irtl_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .kind  (kind),
    .done  (done)
);

/* tb/tb_top.sv */
// self-checking testbench for ip_range_table_lookup: loads table words and looks up
// addresses, predicting each record address from a shadow copy of the table memory
// depends on irtl_pkg and the ip_range_table_lookup rtl
module tb_top;
    import irtl_pkg::*;

    typedef logic [WORD_ADDR_BITS-1:0] widx_t;

    typedef struct packed {
        logic [31:0] rec_addr;
        logic        in_block;
    } record_t;

    localparam int ITEM_TARGET   = 1700;
    localparam int DRAIN_CYCLES  = 4 + 2 * (MAX_SCAN + 1) + 16;
    localparam int STALL_LIMIT   = 5000;
    localparam logic [31:0] TOP_CROSS_OFFSET = 32'h00F7_FFF8;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        kind;
    widx_t       word_addr;
    logic [31:0] word_data;
    logic [31:0] ip_addr;
    logic        done;
    logic [31:0] record_addr;
    logic        matched_in_block;

    logic [31:0] table_shadow [widx_t];
    widx_t       list_words[$];
    record_t     expected_records[$];

    int unsigned items_sent;
    int unsigned write_count;
    int unsigned result_count;
    int unsigned hit_count;
    int unsigned error_count;
    int unsigned stall_cycles;
    bit          no_gaps;

    ip_range_table_lookup dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .kind             (kind),
        .word_addr        (word_addr),
        .word_data        (word_data),
        .ip_addr          (ip_addr),
        .done             (done),
        .record_addr      (record_addr),
        .matched_in_block (matched_in_block)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] stored_word(input widx_t a);
        return table_shadow.exists(a) ? table_shadow[a] : 32'd0;
    endfunction

    function automatic widx_t list_word(input logic [31:0] offset, input int unsigned pos);
        widx_t idx;
        idx = LIST_BASE_WORD + widx_t'(offset >> 2) + widx_t'(pos);
        return idx;
    endfunction

    function automatic widx_t entry_word(input logic [15:0] prefix);
        widx_t idx;
        idx = widx_t'({prefix, 1'b1});
        return idx;
    endfunction

    function automatic int unsigned capped_count(input logic [31:0] count);
        return (count > MAX_SCAN) ? MAX_SCAN : count;
    endfunction

    // walk the range list the way the block does and form the record address
    function automatic record_t predict_record(input logic [31:0] ip);
        record_t     r;
        widx_t       ent;
        widx_t       idx;
        logic [31:0] w;
        int unsigned scan;
        ent = entry_word(ip[31:16]);
        scan = capped_count(stored_word(ent + 1'b1));
        idx = list_word(stored_word(ent), 0);
        r.in_block = 1'b0;
        for (int i = 0; i < scan; i++)
        begin
            w = stored_word(idx);
            if (ip[15:8] <= w[7:0])
            begin
                r.in_block = 1'b1;
                break;
            end
            idx++;
        end
        r.rec_addr = stored_word(widx_t'(0)) + (stored_word(idx) >> 8);
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_offset();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(0, 4095) * 4;
        else if (r < 90)
            return $urandom_range(0, 4095) * 4 + $urandom_range(1, 3);
        else
            return $urandom;
    endfunction

    function automatic logic [31:0] pick_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 4);
        else if (r < 90)
            return $urandom_range(5, 16);
        else if (r < 97)
            return $urandom_range(17, 64);
        case ($urandom_range(0, 3))
            0:       return MAX_SCAN;
            1:       return MAX_SCAN + 1;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // one transaction; start stays high when the next one follows without a gap
    task automatic send_item(input logic k, input widx_t a, input logic [31:0] d,
                             input logic [31:0] ip);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        kind      <= k;
        word_addr <= a;
        word_data <= d;
        ip_addr   <= ip;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if (k == KIND_WRITE)
        begin
            table_shadow[a] = d;
            write_count++;
        end
        else
            expected_records.push_back(predict_record(ip));
    endtask

    task automatic write_word(input widx_t a, input logic [31:0] d);
        send_item(KIND_WRITE, a, d, $urandom);
    endtask

    task automatic write_entry(input logic [15:0] prefix, input logic [31:0] offset,
                               input logic [31:0] count);
        widx_t idx;
        idx = entry_word(prefix);
        write_word(idx, offset);
        write_word(idx + 1'b1, count);
    endtask

    task automatic fill_list_word(input widx_t a, input logic [7:0] octet, input bit force_miss);
        logic [31:0] d;
        d = $urandom;
        if (force_miss && octet != 8'd0)
            d[7:0] = 8'($urandom_range(0, octet - 1));
        write_word(a, d);
        list_words.push_back(a);
    endtask

    // writes every word the lookup will read that is still unwritten
    task automatic ensure_path(input logic [31:0] ip, input bit force_miss);
        widx_t       ent;
        widx_t       cnt_idx;
        widx_t       idx;
        int unsigned scan;
        logic [31:0] w;
        if (!table_shadow.exists(widx_t'(0)))
            write_word('0, $urandom);
        ent = entry_word(ip[31:16]);
        cnt_idx = ent + 1'b1;
        if (!table_shadow.exists(ent))
            write_word(ent, pick_offset());
        if (!table_shadow.exists(cnt_idx))
            write_word(cnt_idx, pick_count());
        scan = capped_count(table_shadow[cnt_idx]);
        idx = list_word(table_shadow[ent], 0);
        for (int i = 0; i < scan; i++)
        begin
            if (!table_shadow.exists(idx))
                fill_list_word(idx, ip[15:8], force_miss);
            w = table_shadow[idx];
            if (ip[15:8] <= w[7:0])
                return;
            idx++;
        end
        if (!table_shadow.exists(idx))
            fill_list_word(idx, ip[15:8], force_miss);
    endtask

    task automatic run_lookup(input logic [31:0] ip, input bit force_miss);
        ensure_path(ip, force_miss);
        send_item(KIND_LOOKUP, widx_t'($urandom), $urandom, ip);
    endtask

    task automatic test_scan_order();
        no_gaps = 1'b0;
        write_word('0, $urandom);
        write_entry(16'h0001, 32'h100, 32'd3);
        write_word(list_word(32'h100, 0), {24'($urandom), 8'h10});
        write_word(list_word(32'h100, 1), {24'($urandom), 8'h20});
        write_word(list_word(32'h100, 2), {24'($urandom), 8'h30});
        write_word(list_word(32'h100, 3), {24'($urandom), 8'h05});
        run_lookup({16'h0001, 8'h00, 8'($urandom)}, 1'b0);
        run_lookup({16'h0001, 8'h20, 8'($urandom)}, 1'b0);
        run_lookup({16'h0001, 8'h21, 8'($urandom)}, 1'b0);
        // above every low byte: the word past the list is taken
        run_lookup({16'h0001, 8'h31, 8'($urandom)}, 1'b0);
    endtask

    task automatic test_count_zero();
        write_entry(16'h0000, 32'h40, 32'd0);
        write_word(list_word(32'h40, 0), {24'($urandom), 8'hFF});
        run_lookup(32'h0000_0000, 1'b0);
        write_entry(16'h0000, 32'h40, 32'd1);
        run_lookup(32'h0000_0000, 1'b0);
    endtask

    task automatic test_scan_cap();
        write_entry(16'hFFFF, 32'h1_0000, 32'hFFFF_FFFF);
        run_lookup(32'hFFFF_FFFF, 1'b1);
        // match on the last word that the cap still allows
        write_word(list_word(32'h1_0000, MAX_SCAN - 1), {24'($urandom), 8'hFF});
        write_entry(16'hFFFF, 32'h1_0000, MAX_SCAN);
        run_lookup(32'hFFFF_FFFF, 1'b0);
        // match only just beyond the cap must not count
        write_word(list_word(32'h1_0000, MAX_SCAN - 1), {24'($urandom), 8'h00});
        write_word(list_word(32'h1_0000, MAX_SCAN), {24'($urandom), 8'hFF});
        write_entry(16'hFFFF, 32'h1_0000, MAX_SCAN + 1);
        run_lookup(32'hFFFF_FF00, 1'b0);
    endtask

    task automatic test_offsets();
        write_entry(16'h0002, 32'h103, 32'd3);
        run_lookup({16'h0002, 8'h21, 8'($urandom)}, 1'b0);
        // offset wraps the word index around the top of memory
        write_entry(16'h0003, 32'hFFFF_FFFC, 32'd4);
        run_lookup({16'h0003, 8'($urandom), 8'($urandom)}, 1'b0);
        // list runs off the last word and continues at word zero
        write_entry(16'h0004, TOP_CROSS_OFFSET, 32'd3);
        run_lookup({16'h0004, 8'hFF, 8'($urandom)}, 1'b1);
    endtask

    task automatic test_sum_wrap();
        write_entry(16'h0005, 32'h300, 32'd1);
        write_word(list_word(32'h300, 0), 32'hFFFF_FFFF);
        write_word('0, 32'hFFFF_FFFF);
        run_lookup({16'h0005, 8'h00, 8'($urandom)}, 1'b0);
        write_word('0, 32'h0000_0000);
        run_lookup({16'h0005, 8'hFF, 8'($urandom)}, 1'b0);
        write_word('0, $urandom);
    endtask

    task automatic test_back_to_back();
        no_gaps = 1'b1;
        write_word('1, 32'h0000_0000);
        write_word('1, 32'hFFFF_FFFF);
        repeat (4)
        begin
            write_word(list_word(32'h100, 1), $urandom);
            run_lookup({16'h0001, 8'($urandom), 8'($urandom)}, 1'b0);
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [15:0] prefixes[$];
        logic [15:0] pfx;
        int unsigned r;
        int unsigned iter;
        prefixes = '{16'h0000, 16'hFFFF};
        repeat (14) prefixes.push_back(16'($urandom));
        iter = 0;
        while (items_sent < ITEM_TARGET)
        begin
            iter++;
            if (iter % 100 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            pfx = prefixes[$urandom_range(0, prefixes.size() - 1)];
            r = $urandom_range(0, 99);
            if (r < 8)
                write_entry(pfx, pick_offset(), pick_count());
            else if (r < 16 && list_words.size() > 0)
                write_word(list_words[$urandom_range(0, list_words.size() - 1)], $urandom);
            else if (r < 20)
                write_word(widx_t'($urandom), $urandom);
            else if (r < 23)
                case ($urandom_range(0, 3))
                    0:       write_word('0, 32'h0000_0000);
                    1:       write_word('0, 32'hFFFF_FFFF);
                    default: write_word('0, $urandom);
                endcase
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    pfx = 16'($urandom);
                run_lookup({pfx, 16'($urandom)}, $urandom_range(0, 9) == 0);
            end
        end
    endtask

    // result checker: the receiver side has no stall, every done is one transaction
    always @(posedge clk)
    begin
        record_t want;
        if (rst_n && done)
        begin
            result_count++;
            if (matched_in_block === 1'b1)
                hit_count++;
            if (expected_records.size() == 0)
            begin
                $error("result with no lookup pending: record_addr=%h matched_in_block=%b",
                       record_addr, matched_in_block);
                error_count++;
            end
            else
            begin
                want = expected_records.pop_front();
                if (record_addr !== want.rec_addr)
                begin
                    $error("record_addr: expected %h, got %h", want.rec_addr, record_addr);
                    error_count++;
                end
                if (matched_in_block !== want.in_block)
                begin
                    $error("matched_in_block: expected %b, got %b",
                           want.in_block, matched_in_block);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted transaction or result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no progress for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        kind      = KIND_WRITE;
        word_addr = '0;
        word_data = '0;
        ip_addr   = '0;
        no_gaps   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_scan_order();
        test_count_zero();
        test_scan_cap();
        test_offsets();
        test_sum_wrap();
        test_back_to_back();
        test_random_traffic();

        start <= 1'b0;
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_records.size() != 0)
        begin
            $error("%0d lookups never produced a result", expected_records.size());
            error_count++;
        end

        $display("covered %0d transactions: %0d table writes, %0d lookups checked",
                 items_sent, write_count, result_count);
        $display("lookups ended in-block %0d times and by fallback %0d times",
                 hit_count, result_count - hit_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* ip_range_table_lookup.f */
+incdir+src
src/irtl_pkg.sv
src/irtl_ram.sv
src/irtl_seq.sv
src/ip_range_table_lookup.sv
src/irtl_checker.sv
tb/tb_top.sv
